// ===== hw/rtl/utf8_stream_decoder_unit_assert.svh =====
// Assertion macros for the UTF-8 stream decoder checker
`ifndef UTF8_STREAM_DECODER_UNIT_ASSERT_SVH
`define UTF8_STREAM_DECODER_UNIT_ASSERT_SVH

// Check a property on every clock edge outside reset
`define U8D_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error(msg);

// Check a property on every clock edge, reset included
`define U8D_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

// ===== hw/rtl/u8d_pkg.sv =====
// Shared types and constants of the UTF-8 stream decoder
`default_nettype none

package u8d_pkg;

    // Byte classes sorted out by the front end
    typedef enum logic [2:0] {
        CLS_ASCII,
        CLS_CONT,
        CLS_LEAD2,
        CLS_LEAD3,
        CLS_LEAD4,
        CLS_BAD
    } t_byte_class;

    // One classified byte as it waits in the queue
    typedef struct packed {
        t_byte_class cls;
        logic [6:0]  bits;
    } t_q_item;

    // Queue between front and back end
    localparam int QAW    = 2;
    localparam int QDEPTH = 1 << QAW;

    // Code point limits
    localparam logic [20:0] CP_SURR_LO  = 21'h00D800;
    localparam logic [20:0] CP_SURR_HI  = 21'h00DFFF;
    localparam logic [20:0] CP_MIN2     = 21'h000080;
    localparam logic [20:0] CP_MAX2     = 21'h0007FF;
    localparam logic [20:0] CP_MIN3     = 21'h000800;
    localparam logic [20:0] CP_MAX3     = 21'h00FFFF;
    localparam logic [20:0] CP_MIN4     = 21'h010000;
    localparam logic [20:0] CP_MAX4     = 21'h10FFFF;

endpackage

`default_nettype wire

// ===== hw/rtl/u8d_front.sv =====
// Front end: accept bytes and classify them for the queue
`default_nettype none

module u8d_front
    import u8d_pkg::*;
(
    input  wire logic       i_push,
    input  wire logic [7:0] i_data_byte,
    input  wire logic       i_full,
    output t_q_item         o_item,
    output logic            o_push
);

    // Sort the byte by its leading ones
    function automatic t_byte_class classify(input logic [7:0] b);
        t_byte_class c;
        case (b) inside
            [8'h00:8'h7F]: c = CLS_ASCII;
            [8'h80:8'hBF]: c = CLS_CONT;
            [8'hC0:8'hDF]: c = CLS_LEAD2;
            [8'hE0:8'hEF]: c = CLS_LEAD3;
            [8'hF0:8'hF7]: c = CLS_LEAD4;
            default:       c = CLS_BAD;
        endcase
        return c;
    endfunction

    // Pass the classified byte on when the queue has room
    always_comb begin
        o_item.cls  = classify(i_data_byte);
        o_item.bits = i_data_byte[6:0];
        o_push      = i_push && !i_full;
    end

endmodule

`default_nettype wire

// ===== hw/rtl/u8d_queue.sv =====
// Small queue of classified bytes between front and back end
`default_nettype none

module u8d_queue
    import u8d_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_push,
    input  wire t_q_item i_item,
    output logic         o_full,
    input  wire logic    i_pop,
    output t_q_item      o_item,
    output logic         o_empty
);

    t_q_item          r_mem [QDEPTH];
    logic [QAW-1:0]   r_wr_ptr, n_wr_ptr;
    logic [QAW-1:0]   r_rd_ptr, n_rd_ptr;
    logic [QAW:0]     r_count,  n_count;

    // Advance pointers and count
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = r_wr_ptr + 1'b1;
        end
        if (i_pop) begin
            n_rd_ptr = r_rd_ptr + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_push && i_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // Store the incoming transaction
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

    assign o_item  = r_mem[r_rd_ptr];
    assign o_full  = (r_count == (QAW+1)'(QDEPTH));
    assign o_empty = (r_count == '0);

endmodule

`default_nettype wire

// ===== hw/rtl/u8d_back.sv =====
// Back end: sequence decoding, value checks and result register
`default_nettype none

module u8d_back
    import u8d_pkg::*;
(
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire t_q_item      i_item,
    input  wire logic         i_q_empty,
    output logic              o_q_pop,
    input  wire logic         i_pop,
    output logic              o_empty,
    output logic [20:0]       o_code_point,
    output logic [2:0]        o_seq_bytes,
    output logic              o_error
);

    logic [1:0]  r_pending, n_pending;
    logic [2:0]  r_total,   n_total;
    logic [20:0] r_code,    n_code;
    logic        r_out_valid, n_out_valid;
    logic [20:0] r_cp;
    logic [2:0]  r_len;
    logic        r_err;

    logic        adv;
    logic        res_valid;
    logic [20:0] res_cp;
    logic [2:0]  res_len;
    logic        res_err;
    logic [20:0] acc;

    // Check a finished value against its length
    function automatic logic value_ok(input logic [20:0] cp, input logic [2:0] len);
        logic ok;
        if (cp >= CP_SURR_LO && cp <= CP_SURR_HI) begin
            ok = 1'b0;
        end else begin
            case (len)
                3'd2:    ok = (cp >= CP_MIN2) && (cp <= CP_MAX2);
                3'd3:    ok = (cp >= CP_MIN3) && (cp <= CP_MAX3);
                3'd4:    ok = (cp >= CP_MIN4) && (cp <= CP_MAX4);
                default: ok = 1'b0;
            endcase
        end
        return ok;
    endfunction

    // Take a queued byte whenever the result slot is free or being drained
    assign adv     = !i_q_empty && (!r_out_valid || i_pop);
    assign o_q_pop = adv;
    assign acc     = {r_code[14:0], i_item.bits[5:0]};

    // Decode one byte
    always_comb begin
        n_pending = r_pending;
        n_total   = r_total;
        n_code    = r_code;
        res_valid = 1'b0;
        res_cp    = '0;
        res_len   = 3'd1;
        res_err   = 1'b0;
        if (adv) begin
            if (r_pending == 2'd0) begin
                case (i_item.cls)
                    CLS_ASCII: begin
                        res_valid = 1'b1;
                        res_cp    = {14'd0, i_item.bits};
                    end
                    CLS_LEAD2: begin
                        n_total   = 3'd2;
                        n_pending = 2'd1;
                        n_code    = {16'd0, i_item.bits[4:0]};
                    end
                    CLS_LEAD3: begin
                        n_total   = 3'd3;
                        n_pending = 2'd2;
                        n_code    = {17'd0, i_item.bits[3:0]};
                    end
                    CLS_LEAD4: begin
                        n_total   = 3'd4;
                        n_pending = 2'd3;
                        n_code    = {18'd0, i_item.bits[2:0]};
                    end
                    default: begin
                        // stray continuation or invalid lead
                        res_valid = 1'b1;
                        res_err   = 1'b1;
                    end
                endcase
            end else if (i_item.cls != CLS_CONT) begin
                // drop the byte that broke the sequence and go idle
                res_valid = 1'b1;
                res_err   = 1'b1;
                res_len   = r_total - {1'b0, r_pending} + 3'd1;
                n_pending = '0;
                n_total   = '0;
                n_code    = '0;
            end else if (r_pending == 2'd1) begin
                res_valid = 1'b1;
                res_len   = r_total;
                if (value_ok(acc, r_total)) begin
                    res_cp = acc;
                end else begin
                    res_err = 1'b1;
                end
                n_pending = '0;
                n_total   = '0;
                n_code    = '0;
            end else begin
                n_pending = r_pending - 2'd1;
                n_code    = acc;
            end
        end
    end

    // Load a new result or release the taken one
    always_comb begin
        n_out_valid = r_out_valid;
        if (res_valid) begin
            n_out_valid = 1'b1;
        end else if (i_pop) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pending   <= '0;
            r_total     <= '0;
            r_code      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_pending   <= n_pending;
            r_total     <= n_total;
            r_code      <= n_code;
            r_out_valid <= n_out_valid;
        end
    end

    // Hold the result payload
    always_ff @(posedge i_clk) begin
        if (res_valid) begin
            r_cp  <= res_cp;
            r_len <= res_len;
            r_err <= res_err;
        end
    end

    assign o_empty      = !r_out_valid;
    assign o_code_point = r_cp;
    assign o_seq_bytes  = r_len;
    assign o_error      = r_err;

endmodule

`default_nettype wire

// ===== hw/rtl/utf8_stream_decoder_unit.sv =====
// Strict UTF-8 stream decoder: one byte in, at most one code point or error out.
// Bytes are pushed on a queue-like input and classified at once; a four-entry queue
// feeds the decoder, which takes one byte per clock and writes each finished code point
// or error into a single result register that is read like a queue. The sustained rate
// is one byte per cycle, set by the decoder consuming one queued byte each cycle while
// the result register is free or being popped. With the queue empty and the result
// register free, the byte ending a sequence passes through the queue and is decoded
// into the result register, which drives the outputs. While a result waits unpopped
// the decoder stops, and after at most four more bytes the input reports full. Lead
// bytes and inner continuation bytes produce no result; an invalid byte produces an
// error result with a zero code point.
`default_nettype none

module utf8_stream_decoder_unit
    import u8d_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_push,
    input  wire logic [7:0]  i_data_byte,
    output logic             o_full,
    input  wire logic        i_pop,
    output logic             o_empty,
    output logic [20:0]      o_code_point,
    output logic [2:0]       o_seq_bytes,
    output logic             o_error
);

    t_q_item in_item;
    t_q_item out_item;
    logic    q_push;
    logic    q_pop;
    logic    q_empty;

    u8d_front u_front (
        .i_push      (i_push),
        .i_data_byte (i_data_byte),
        .i_full      (o_full),
        .o_item      (in_item),
        .o_push      (q_push)
    );

    u8d_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_item  (in_item),
        .o_full  (o_full),
        .i_pop   (q_pop),
        .o_item  (out_item),
        .o_empty (q_empty)
    );

    u8d_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_item       (out_item),
        .i_q_empty    (q_empty),
        .o_q_pop      (q_pop),
        .i_pop        (i_pop),
        .o_empty      (o_empty),
        .o_code_point (o_code_point),
        .o_seq_bytes  (o_seq_bytes),
        .o_error      (o_error)
    );

endmodule

`default_nettype wire

// ===== hw/rtl/u8d_checker.sv =====
// Port-level checker for the UTF-8 stream decoder, bound to the top level
`default_nettype none

`include "utf8_stream_decoder_unit_assert.svh"

module u8d_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_push,
    input wire logic [7:0]  i_data_byte,
    input wire logic        o_full,
    input wire logic        i_pop,
    input wire logic        o_empty,
    input wire logic [20:0] o_code_point,
    input wire logic [2:0]  o_seq_bytes,
    input wire logic        o_error
);

    // Reset leaves no result waiting and room for input
    `U8D_ASSERT_ALWAYS(a_reset_clears, !i_rst_n |=> (o_empty && !o_full), "not clear after reset")

    // An error result carries a zero code point
    `U8D_ASSERT(a_err_zero_cp, (!o_empty && o_error) |-> (o_code_point == 21'd0), "error with nonzero code point")

    // A valid single-byte result is ASCII
    `U8D_ASSERT(a_one_byte_ascii, (!o_empty && !o_error && o_seq_bytes == 3'd1) |-> (o_code_point[20:7] == 14'd0), "one-byte result above ASCII")

    // A stalled result transaction holds its payload
    `U8D_ASSERT(a_hold_result, (!o_empty && !i_pop) |=> (!o_empty && $stable(o_code_point) && $stable(o_seq_bytes) && $stable(o_error)), "stalled result changed")

endmodule

bind utf8_stream_decoder_unit u8d_checker u_u8d_checker (.*);

`default_nettype wire

// ===== verif/testbench.sv =====
// Self-checking testbench for the UTF-8 stream decoder unit
`default_nettype none

module testbench;
    import u8d_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CLK_HALF     = 6;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int DRAIN_CYCLES = 12;
    localparam int HOLD_CYCLES  = 150;
    localparam int PHASE_BYTES  = 165;

    // One decoded code point or error as it leaves the block
    typedef struct packed {
        logic [20:0] cp;
        logic [2:0]  nbytes;
        logic        err;
    } cp_result_t;

    logic        i_clk       = 1'b0;
    logic        i_rst_n     = 1'b0;
    logic        i_push      = 1'b0;
    logic [7:0]  i_data_byte = 8'h00;
    logic        i_pop       = 1'b0;
    logic        o_full;
    logic        o_empty;
    logic [20:0] o_code_point;
    logic [2:0]  o_seq_bytes;
    logic        o_error;

    utf8_stream_decoder_unit DUT (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (i_push),
        .i_data_byte  (i_data_byte),
        .o_full       (o_full),
        .i_pop        (i_pop),
        .o_empty      (o_empty),
        .o_code_point (o_code_point),
        .o_seq_bytes  (o_seq_bytes),
        .o_error      (o_error)
    );

    // Stream bytes waiting to be pushed and code points waiting to come out
    logic [7:0]  stream_q[$];
    cp_result_t  cp_expect_q[$];

    // Decoder state as the predictor sees it
    logic [1:0]  dec_left = '0;
    logic [2:0]  dec_len  = '0;
    logic [20:0] dec_acc  = '0;

    int unsigned send_idle_pct = 0;
    int unsigned recv_idle_pct = 0;
    int unsigned hold_requests = 0;
    int unsigned hold_served   = 0;
    int unsigned hold_left     = 0;
    int unsigned cycle_cnt     = 0;
    int unsigned mismatch_cnt  = 0;
    int unsigned bytes_taken   = 0;
    int unsigned cp_seen       = 0;
    int unsigned err_seen      = 0;
    int unsigned full_seen     = 0;

    // Advance the predicted decoder by one byte, queue any result it yields
    task automatic utf8_step(input logic [7:0] b);
        int          ones;
        logic [7:0]  payload_mask;
        logic        cp_ok;
        cp_result_t  res;
        ones = 0;
        if (dec_left == 2'd0) begin
            if (!b[7]) begin
                res = '{cp: {13'd0, b}, nbytes: 3'd1, err: 1'b0};
                cp_expect_q.push_back(res);
            end else begin
                for (int k = 7; k >= 0 && b[k]; k--)
                    ones++;
                if (ones < 2 || ones > 4) begin
                    res = '{cp: '0, nbytes: 3'd1, err: 1'b1};
                    cp_expect_q.push_back(res);
                end else begin
                    payload_mask = (8'h01 << (7 - ones)) - 8'h01;
                    dec_len  = 3'(ones);
                    dec_left = 2'(ones - 1);
                    dec_acc  = {13'd0, b & payload_mask};
                end
            end
        end else if (b[7:6] != 2'b10) begin
            // Drop the intruding byte but count it in the failed sequence
            res = '{cp: '0, nbytes: dec_len - 3'(dec_left) + 3'd1, err: 1'b1};
            cp_expect_q.push_back(res);
            dec_left = '0;
            dec_len  = '0;
            dec_acc  = '0;
        end else begin
            dec_acc  = {dec_acc[14:0], b[5:0]};
            dec_left = dec_left - 2'd1;
            if (dec_left == 2'd0) begin
                case (dec_len)
                    3'd2:    cp_ok = dec_acc >= CP_MIN2 && dec_acc <= CP_MAX2;
                    3'd3:    cp_ok = dec_acc >= CP_MIN3 && dec_acc <= CP_MAX3;
                    3'd4:    cp_ok = dec_acc >= CP_MIN4 && dec_acc <= CP_MAX4;
                    default: cp_ok = 1'b0;
                endcase
                if (dec_acc >= CP_SURR_LO && dec_acc <= CP_SURR_HI)
                    cp_ok = 1'b0;
                if (cp_ok)
                    res = '{cp: dec_acc, nbytes: dec_len, err: 1'b0};
                else
                    res = '{cp: '0, nbytes: dec_len, err: 1'b1};
                cp_expect_q.push_back(res);
                dec_left = '0;
                dec_len  = '0;
                dec_acc  = '0;
            end
        end
    endtask

    // Queue a random stretch of stream: mostly well-formed sequences with random
    // payload, some cut short by a foreign byte, some raw noise
    task automatic add_random_stream(input int n_bytes);
        int unsigned kind;
        int unsigned len;
        int unsigned keep;
        int          target;
        target = stream_q.size() + n_bytes;
        while (stream_q.size() < target) begin
            kind = $urandom_range(99);
            len  = $urandom_range(1, 4);
            if (kind < 85) begin
                case (len)
                    1: stream_q.push_back(8'($urandom_range(0, 127)));
                    2: stream_q.push_back(8'hC0 | 8'($urandom_range(0, 31)));
                    3: stream_q.push_back(8'hE0 | 8'($urandom_range(0, 15)));
                    default: stream_q.push_back(8'hF0 | 8'($urandom_range(0, 7)));
                endcase
                // Cut the sequence short now and then with a non-continuation byte
                keep = (kind < 70 || len == 1) ? len - 1 : $urandom_range(0, len - 2);
                repeat (keep)
                    stream_q.push_back(8'h80 | 8'($urandom_range(0, 63)));
                if (keep < len - 1)
                    stream_q.push_back($urandom_range(0, 1) ? 8'($urandom_range(0, 127))
                                                            : 8'($urandom_range(192, 255)));
            end else begin
                stream_q.push_back(8'($urandom_range(0, 255)));
            end
        end
    endtask

    // Clock
    initial begin
        forever #CLK_HALF i_clk = ~i_clk;
    end

    // Run limit
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("%0t: timeout after %0d cycles, %0d results still expected",
                     $time, cycle_cnt, cp_expect_q.size());
            $display("*** FAILED ***");
            $finish;
        end
    end

    // Driver: offer the head of the stream, predict on each accepted transaction
    always @(posedge i_clk) begin : drive_bytes
        if (!i_rst_n) begin
            i_push <= 1'b0;
        end else begin
            if (i_push && !o_full) begin
                utf8_step(i_data_byte);
                void'(stream_q.pop_front());
                bytes_taken <= bytes_taken + 1;
            end
            if (o_full)
                full_seen <= full_seen + 1;
            if (stream_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                i_push      <= 1'b1;
                i_data_byte <= stream_q[0];
            end else begin
                i_push      <= 1'b0;
                i_data_byte <= 8'($urandom);
            end
        end
    end

    // Hold off the receiver for a long stretch on request
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            hold_left <= 0;
        end else if (hold_served != hold_requests) begin
            hold_served <= hold_requests;
            hold_left   <= HOLD_CYCLES;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
        end
    end

    // Monitor: check each popped result against the oldest expectation
    always @(posedge i_clk) begin : check_results
        cp_result_t want;
        if (!i_rst_n) begin
            i_pop <= 1'b0;
        end else begin
            if (i_pop && !o_empty) begin
                if (cp_expect_q.size() == 0) begin
                    $display("%0t: unexpected result cp=%h bytes=%0d err=%b",
                             $time, o_code_point, o_seq_bytes, o_error);
                    mismatch_cnt <= mismatch_cnt + 1;
                end else begin
                    want = cp_expect_q.pop_front();
                    if (o_code_point !== want.cp || o_seq_bytes !== want.nbytes ||
                        o_error !== want.err) begin
                        $display("%0t: mismatch expected cp=%h bytes=%0d err=%b, got cp=%h bytes=%0d err=%b",
                                 $time, want.cp, want.nbytes, want.err,
                                 o_code_point, o_seq_bytes, o_error);
                        mismatch_cnt <= mismatch_cnt + 1;
                    end
                end
                cp_seen <= cp_seen + 1;
                if (o_error === 1'b1)
                    err_seen <= err_seen + 1;
            end
            i_pop <= (hold_left == 0) && ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Stimulus and end of run
    initial begin : stimulus
        logic [7:0] corner_bytes[25];
        // ASCII extremes, stray continuations, bad leads, two-byte edges, overlong,
        // surrogate, broken sequence, largest scalar value and one past it
        corner_bytes = '{8'h00, 8'h7F, 8'h80, 8'hFF, 8'hFE, 8'hF8,
                         8'hC2, 8'h80, 8'hDF, 8'hBF, 8'hC1, 8'hBF,
                         8'hED, 8'hA0, 8'h80, 8'hE2, 8'h41,
                         8'hF4, 8'h8F, 8'hBF, 8'hBF, 8'hF4, 8'h90, 8'h80, 8'h80};
        i_rst_n <= 1'b0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Back to back, with one long receiver hold-off so the input backs up
        foreach (corner_bytes[k])
            stream_q.push_back(corner_bytes[k]);
        add_random_stream(PHASE_BYTES);
        hold_requests = hold_requests + 1;
        while (stream_q.size() != 0) @(negedge i_clk);

        // Sender mostly idle
        send_idle_pct = 54;
        recv_idle_pct = 0;
        add_random_stream(PHASE_BYTES);
        while (stream_q.size() != 0) @(negedge i_clk);

        // Receiver mostly stalled
        send_idle_pct = 0;
        recv_idle_pct = 54;
        add_random_stream(PHASE_BYTES);
        while (stream_q.size() != 0) @(negedge i_clk);

        // Light idling on both sides
        send_idle_pct = 7;
        recv_idle_pct = 7;
        add_random_stream(PHASE_BYTES);
        while (stream_q.size() != 0) @(negedge i_clk);

        // Drain and let the pipeline settle
        while (cp_expect_q.size() != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);

        $display("Decoded %0d stream bytes into %0d results (%0d errors), %0d mismatches.",
                 bytes_taken, cp_seen, err_seen, mismatch_cnt);
        $display("Covered four idle mixes and a receiver hold-off; input full for %0d cycles.",
                 full_seen);
        if (mismatch_cnt == 0 && cp_expect_q.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

`default_nettype wire

// ===== sim.f =====
+incdir+hw/rtl
hw/rtl/u8d_pkg.sv
hw/rtl/u8d_front.sv
hw/rtl/u8d_queue.sv
hw/rtl/u8d_back.sv
hw/rtl/utf8_stream_decoder_unit.sv
hw/rtl/u8d_checker.sv
verif/testbench.sv
